// ===== rtl/pqmbs_pkg.sv =====
// Shared constants, command codes and cell control type for the score priority queue.
package pqmbs_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int FIELD_BITS_DEF = 16;

    // Command codes carried on the input tuser
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_REPORT = 2'd0,
        CMD_REPORT        = 2'd1,
        CMD_REMOVE_REPORT = 2'd2,
        CMD_INSERT_QUIET  = 2'd3
    } cmd_t;

    // Per-cycle operation broadcast to every cell
    typedef struct packed {
        logic ins;   // place the new record, shift beaten ones right
        logic rem;   // shift every record one place left
    } op_t;

endpackage

// ===== rtl/pqmbs_cell.sv =====
// One cell of the sorted record chain: holds one record, compares and shifts.
module pqmbs_cell #(
    parameter int FIELD_BITS = pqmbs_pkg::FIELD_BITS_DEF,
    parameter int OCC_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  pqmbs_pkg::op_t        op,
    input  logic [OCC_W-1:0]      occupancy,
    input  logic [FIELD_BITS-1:0] new_tag,
    input  logic [FIELD_BITS-1:0] new_id,
    input  logic [FIELD_BITS-1:0] new_score,
    input  logic                  left_beat,
    input  logic [FIELD_BITS-1:0] left_tag,
    input  logic [FIELD_BITS-1:0] left_id,
    input  logic [FIELD_BITS-1:0] left_score,
    input  logic [FIELD_BITS-1:0] right_tag,
    input  logic [FIELD_BITS-1:0] right_id,
    input  logic [FIELD_BITS-1:0] right_score,
    output logic                  own_beat,
    output logic [FIELD_BITS-1:0] own_tag,
    output logic [FIELD_BITS-1:0] own_id,
    output logic [FIELD_BITS-1:0] own_score
);

    localparam logic [OCC_W-1:0] INDEX_V = OCC_W'(INDEX);

    logic [FIELD_BITS-1:0] tag_reg,   tag_next;
    logic [FIELD_BITS-1:0] id_reg,    id_next;
    logic [FIELD_BITS-1:0] score_reg, score_next;
    logic                  valid;

    // An empty slot is beaten by any new record; among equals the new one goes behind
    always_comb begin
        valid    = INDEX_V < occupancy;
        own_beat = !valid
                || (new_score > score_reg)
                || ((new_score == score_reg) && (new_id < id_reg));
    end

    // Select the next content: take left on a shift right, new at the insert point,
    // right on a removal, otherwise hold
    always_comb begin
        tag_next   = tag_reg;
        id_next    = id_reg;
        score_next = score_reg;
        if (op.ins) begin
            if (left_beat) begin
                tag_next   = left_tag;
                id_next    = left_id;
                score_next = left_score;
            end else if (own_beat) begin
                tag_next   = new_tag;
                id_next    = new_id;
                score_next = new_score;
            end
        end else if (op.rem) begin
            tag_next   = right_tag;
            id_next    = right_id;
            score_next = right_score;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign own_tag   = tag_reg;
    assign own_id    = id_reg;
    assign own_score = score_reg;

endmodule

// ===== rtl/priority_queue_max_by_score_unit.sv =====
// Top level of the score priority queue: cell chain, occupancy count and result register.
//
// Usage: records enter on the s_ channel; s_tuser carries the command (insert and
// report, report, remove and report, quiet insert) and s_tdata the record.
// Every command but the quiet insert yields one result transaction on the m_
// channel: the best record (highest score, lower id on ties) after the command,
// with is_empty and overflow flags on m_tuser. An empty queue reports zeros.
// Inserting into a full queue drops the record; an insert and report flags overflow.
// The queue is a chain of CAPACITY cells kept in order, best first. All cells
// compare against the incoming record in the same cycle and shift by one place,
// so any command updates the chain in the cycle it is accepted.
// m_tvalid rises when the result register loads, after the pending flag is registered.
// A quiet insert is taken every cycle while no report is pending; after a reporting
// command s_tready stays low until the report stage has loaded the result register
// from cell zero after the update.
// When the receiver stalls, the result waits in the output register and one
// more reporting command is still taken; s_tready then drops until the result leaves.
// Reset (aresetn low, synchronous) holds s_tready low, empties the queue and drops
// any pending result; record contents are not cleared, since empty cells are never reported.
module priority_queue_max_by_score_unit #(
    parameter int CAPACITY   = pqmbs_pkg::CAPACITY_DEF,
    parameter int FIELD_BITS = pqmbs_pkg::FIELD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: rec_tag, rec_id, rec_score (lowest bit up), zero-padded to bytes
    input  logic [((3*FIELD_BITS+7)/8)*8-1:0]    s_tdata,
    // s_tuser: cmd
    input  logic [pqmbs_pkg::CMD_W-1:0]          s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: best_tag, best_id, best_score (lowest bit up), zero-padded to bytes
    output logic [((3*FIELD_BITS+7)/8)*8-1:0]    m_tdata,
    // m_tuser: is_empty, overflow
    output logic [1:0]                           m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready
);

    localparam int DATA_W = ((3*FIELD_BITS+7)/8)*8;
    localparam int OCC_W  = $clog2(CAPACITY+1);
    localparam logic [OCC_W-1:0] FULL_V = OCC_W'(CAPACITY);

    typedef logic [FIELD_BITS-1:0] field_t;

    // Input record
    field_t           in_tag, in_id, in_score;
    pqmbs_pkg::cmd_t  in_cmd;
    logic             in_fire;
    logic             is_full;
    logic             want_ins;
    logic             drop;
    pqmbs_pkg::op_t   op;

    // Chain links
    field_t cell_tag   [CAPACITY];
    field_t cell_id    [CAPACITY];
    field_t cell_score [CAPACITY];
    logic   cell_beat  [CAPACITY];

    // Control and result registers
    logic [OCC_W-1:0] occ_reg,  occ_next;
    logic             pend_reg, pend_next;
    logic             ovf_reg,  ovf_next;
    logic             mv_reg,   mv_next;
    logic [1:0]       mu_reg,   mu_next;
    logic [DATA_W-1:0] md_reg,  md_next;
    logic             load_out;

    // Unpack the input transaction
    always_comb begin
        in_tag   = s_tdata[FIELD_BITS-1:0];
        in_id    = s_tdata[2*FIELD_BITS-1:FIELD_BITS];
        in_score = s_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
        in_cmd   = pqmbs_pkg::cmd_t'(s_tuser);
    end

    assign s_tready = aresetn && !pend_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign is_full  = occ_reg == FULL_V;

    // Decode the command into a chain operation
    always_comb begin
        want_ins = 1'b0;
        op       = '0;
        case (in_cmd)
            pqmbs_pkg::CMD_INSERT_REPORT: want_ins = 1'b1;
            pqmbs_pkg::CMD_INSERT_QUIET:  want_ins = 1'b1;
            pqmbs_pkg::CMD_REMOVE_REPORT: op.rem   = in_fire && (occ_reg != '0);
            pqmbs_pkg::CMD_REPORT:        op       = '0;
            default:                      op       = '0;
        endcase
        op.ins = in_fire && want_ins && !is_full;
        drop   = want_ins && is_full;
    end

    // Row of cells, best record in cell zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   lb;
        field_t lt, li, ls, rt, ri, rs;
        if (i == 0) begin : g_first
            assign lb = 1'b0;
            assign lt = in_tag;
            assign li = in_id;
            assign ls = in_score;
        end else begin : g_mid
            assign lb = cell_beat[i-1];
            assign lt = cell_tag[i-1];
            assign li = cell_id[i-1];
            assign ls = cell_score[i-1];
        end
        if (i == CAPACITY-1) begin : g_last
            assign rt = cell_tag[i];
            assign ri = cell_id[i];
            assign rs = cell_score[i];
        end else begin : g_inner
            assign rt = cell_tag[i+1];
            assign ri = cell_id[i+1];
            assign rs = cell_score[i+1];
        end
        pqmbs_cell #(
            .FIELD_BITS (FIELD_BITS),
            .OCC_W      (OCC_W),
            .INDEX      (i)
        ) u_cell (
            .aclk        (aclk),
            .op          (op),
            .occupancy   (occ_reg),
            .new_tag     (in_tag),
            .new_id      (in_id),
            .new_score   (in_score),
            .left_beat   (lb),
            .left_tag    (lt),
            .left_id     (li),
            .left_score  (ls),
            .right_tag   (rt),
            .right_id    (ri),
            .right_score (rs),
            .own_beat    (cell_beat[i]),
            .own_tag     (cell_tag[i]),
            .own_id      (cell_id[i]),
            .own_score   (cell_score[i])
        );
    end

    // Advance occupancy and mark a pending report
    always_comb begin
        occ_next  = occ_reg;
        pend_next = pend_reg;
        ovf_next  = ovf_reg;
        if (op.ins) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (op.rem) begin
            occ_next = occ_reg - OCC_W'(1);
        end
        if (load_out) begin
            pend_next = 1'b0;
        end
        if (in_fire && (in_cmd != pqmbs_pkg::CMD_INSERT_QUIET)) begin
            pend_next = 1'b1;
            ovf_next  = drop;
        end
    end

    // Load the result register from cell zero once it is free
    assign load_out = pend_reg && (!mv_reg || m_tready);

    always_comb begin
        mv_next = mv_reg;
        mu_next = mu_reg;
        md_next = md_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        if (load_out) begin
            mv_next = 1'b1;
            if (occ_reg == '0) begin
                mu_next = {ovf_reg, 1'b1};
                md_next = '0;
            end else begin
                mu_next = {ovf_reg, 1'b0};
                md_next = DATA_W'({cell_score[0], cell_id[0], cell_tag[0]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= '0;
            pend_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            occ_reg  <= occ_next;
            pend_reg <= pend_next;
            mv_reg   <= mv_next;
        end
        ovf_reg <= ovf_next;
        mu_reg  <= mu_next;
        md_reg  <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mu_reg;
    assign m_tdata  = md_reg;

endmodule

// ===== sim/priority_queue_max_by_score_unit_test.sv =====
// Self-checking testbench for the score priority queue: directed table, then random traffic.
`timescale 1ns / 100ps

module priority_queue_max_by_score_unit_test;
    import pqmbs_pkg::*;

    localparam int FB         = FIELD_BITS_DEF;
    localparam int QCAP       = CAPACITY_DEF;
    localparam int DW         = ((3 * FB + 7) / 8) * 8;
    localparam int RAND_ITEMS = 550;
    localparam int HOLD_LEN   = 400;

    // Record as it travels on tdata: tag lowest, then id, then score
    typedef struct packed {
        logic [FB-1:0] score;
        logic [FB-1:0] id;
        logic [FB-1:0] tag;
    } rec_t;

    typedef struct packed {
        logic is_empty;
        logic overflow;
        rec_t best;
    } report_t;

    typedef struct packed {
        cmd_t    cmd;
        rec_t    rec;
        logic    fixed;   // expected report typed in below
        report_t want;
    } script_row_t;

    typedef enum {FILL_UP, DRAIN_DOWN, CHURN} traffic_t;

    localparam report_t EMPTY_RPT = '{1'b1, 1'b0, '{'0, '0, '0}};

    // Directed table; record patterns read score, id, tag
    localparam int SCRIPT_LEN = 24;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_REPORT,        '{16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_RPT},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_RPT},
        '{CMD_INSERT_QUIET,  '{16'h0000, 16'hffff, 16'hffff}, 1'b0, '0},
        '{CMD_REPORT,        '{16'h0000, 16'h0000, 16'h0000}, 1'b1,
            '{1'b0, 1'b0, '{16'h0000, 16'hffff, 16'hffff}}},
        '{CMD_INSERT_REPORT, '{16'hffff, 16'h0000, 16'h0000}, 1'b1,
            '{1'b0, 1'b0, '{16'hffff, 16'h0000, 16'h0000}}},
        // same score and id: the earlier record stays in front
        '{CMD_INSERT_REPORT, '{16'hffff, 16'h0000, 16'h5a5a}, 1'b1,
            '{1'b0, 1'b0, '{16'hffff, 16'h0000, 16'h0000}}},
        '{CMD_INSERT_REPORT, '{16'hffff, 16'h0001, 16'ha5a5}, 1'b1,
            '{1'b0, 1'b0, '{16'hffff, 16'h0000, 16'h0000}}},
        '{CMD_INSERT_QUIET,  '{16'hfffe, 16'h0000, 16'h1111}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'hffff, 16'hffff, 16'hffff}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_RPT},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_RPT},
        '{CMD_INSERT_REPORT, '{16'h7fff, 16'h8000, 16'h8001}, 1'b1,
            '{1'b0, 1'b0, '{16'h7fff, 16'h8000, 16'h8001}}},
        '{CMD_INSERT_REPORT, '{16'h8000, 16'h7fff, 16'h0001}, 1'b0, '0},
        '{CMD_INSERT_REPORT, '{16'h8000, 16'h0000, 16'hc3c3}, 1'b0, '0},
        '{CMD_INSERT_QUIET,  '{16'h0001, 16'hffff, 16'h3c3c}, 1'b0, '0},
        '{CMD_REPORT,        '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{CMD_REMOVE_REPORT, '{16'h0000, 16'h0000, 16'h0000}, 1'b1, EMPTY_RPT}
    };

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic [DW-1:0] s_tdata  = '0;
    logic [1:0]    s_tuser  = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tvalid;
    logic          m_tready = 1'b0;

    // Shadow of the queue contents, best first
    rec_t    held_recs [QCAP];
    int      held_count    = 0;
    int      peak_count    = 0;
    report_t awaited_reports [$];

    int mismatches      = 0;
    int reports_checked = 0;
    int empty_reports   = 0;
    int overflow_seen   = 0;
    int items_sent      = 0;
    bit steady          = 1'b0;
    bit hold_req        = 1'b0;

    always #2 aclk = ~aclk;

    priority_queue_max_by_score_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Higher score first; lower id breaks a tie
    function automatic bit outranks(input rec_t a, input rec_t b);
        if (a.score != b.score) return a.score > b.score;
        return a.id < b.id;
    endfunction

    // Place behind every record the new one does not beat; refuse when full
    function automatic bit store_rec(input rec_t r);
        int pos;
        int k;
        pos = 0;
        if (held_count >= QCAP) return 1'b0;
        while (pos < held_count && !outranks(r, held_recs[pos])) pos++;
        for (k = held_count; k > pos; k--) held_recs[k] = held_recs[k-1];
        held_recs[pos] = r;
        held_count++;
        if (held_count > peak_count) peak_count = held_count;
        return 1'b1;
    endfunction

    // Work out the queue update and the report for one accepted command
    task automatic apply_command(input cmd_t c, input rec_t r,
                                 output bit has_rpt, output report_t rpt);
        int  k;
        bit  dropped;
        dropped = 1'b0;
        has_rpt = 1'b1;
        case (c)
            CMD_INSERT_REPORT: dropped = !store_rec(r);
            CMD_REMOVE_REPORT: begin
                if (held_count > 0) begin
                    for (k = 1; k < held_count; k++) held_recs[k-1] = held_recs[k];
                    held_count--;
                end
            end
            CMD_INSERT_QUIET: begin
                void'(store_rec(r));
                has_rpt = 1'b0;
            end
            default: ;
        endcase
        if (held_count == 0) rpt = EMPTY_RPT;
        else rpt = '{1'b0, 1'b0, held_recs[0]};
        rpt.overflow = dropped;
    endtask

    // Offer one command, hold it until accepted, then maybe idle
    task automatic offer(input cmd_t c, input rec_t r, input bit fixed, input report_t want);
        bit      has_rpt;
        report_t rpt;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= DW'(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_command(c, r, has_rpt, rpt);
        if (has_rpt) awaited_reports.push_back(fixed ? want : rpt);
        items_sent++;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Key values biased toward ties and the top of the range
    function automatic logic [FB-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2: return FB'($urandom_range(0, 3));
            3:       return {FB{1'b1}} - FB'($urandom_range(0, 1));
            default: return FB'($urandom());
        endcase
    endfunction

    function automatic cmd_t pick_cmd(input traffic_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            FILL_UP:
                return r < 45 ? CMD_INSERT_QUIET : r < 80 ? CMD_INSERT_REPORT :
                       r < 90 ? CMD_REPORT : CMD_REMOVE_REPORT;
            DRAIN_DOWN:
                return r < 60 ? CMD_REMOVE_REPORT : r < 75 ? CMD_REPORT :
                       r < 90 ? CMD_INSERT_REPORT : CMD_INSERT_QUIET;
            default:
                return cmd_t'(r % 4);
        endcase
    endfunction

    // Check each result transaction against the oldest expected report
    always @(posedge aclk) begin
        report_t want;
        rec_t    got;
        if (aresetn && m_tvalid && m_tready) begin
            got = rec_t'(m_tdata[3*FB-1:0]);
            if (awaited_reports.size() == 0) begin
                $error("result transaction with no report expected");
                mismatches++;
            end else begin
                want = awaited_reports.pop_front();
                reports_checked++;
                if (want.is_empty) empty_reports++;
                if (want.overflow) overflow_seen++;
                if (m_tuser[0] !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_tuser[1]);
                    mismatches++;
                end
                if (got.tag !== want.best.tag) begin
                    $error("best_tag: expected %h, got %h", want.best.tag, got.tag);
                    mismatches++;
                end
                if (got.id !== want.best.id) begin
                    $error("best_id: expected %h, got %h", want.best.id, got.id);
                    mismatches++;
                end
                if (got.score !== want.best.score) begin
                    $error("best_score: expected %h, got %h", want.best.score, got.score);
                    mismatches++;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, steady at the end
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else if (steady || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                repeat (steady ? 1 : $urandom_range(1, 20)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    // Sender: reset, directed table, shaped random traffic, drain
    initial begin
        traffic_t mode;
        cmd_t     c;
        rec_t     r;
        int       full_hits;
        int       empty_hits;
        int       churn_left;
        mode       = FILL_UP;
        full_hits  = 0;
        empty_hits = 0;
        churn_left = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            offer(SCRIPT[i].cmd, SCRIPT[i].rec, SCRIPT[i].fixed, SCRIPT[i].want);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - 60) steady = 1'b1;
            if (n == 150) hold_req = 1'b1;
            // swing between filling to overflow and draining past empty, at times with a spell of churn
            case (mode)
                FILL_UP: if (held_count == QCAP && full_hits >= 6) begin
                    mode      = DRAIN_DOWN;
                    full_hits = 0;
                end
                DRAIN_DOWN: if (held_count == 0 && empty_hits >= 3) begin
                    mode       = $urandom_range(0, 1) ? FILL_UP : CHURN;
                    empty_hits = 0;
                    churn_left = 40;
                end
                default: begin
                    if (churn_left == 0) mode = FILL_UP;
                    else churn_left--;
                end
            endcase
            c = pick_cmd(mode);
            r = '{pick_key(), pick_key(), FB'($urandom())};
            if (held_count == QCAP && (c == CMD_INSERT_REPORT || c == CMD_INSERT_QUIET))
                full_hits++;
            if (held_count == 0 && c == CMD_REMOVE_REPORT) empty_hits++;
            offer(c, r, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("run: %0d commands, %0d reports checked, peak occupancy %0d of %0d",
                 items_sent, reports_checked, peak_count, QCAP);
        $display("run: %0d empty-queue reports, %0d dropped inserts reported, %0d mismatches",
                 empty_reports, overflow_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pqmbs_pkg.sv
rtl/pqmbs_cell.sv
rtl/priority_queue_max_by_score_unit.sv
sim/priority_queue_max_by_score_unit_test.sv
